FILE: design/triangle_noise_sound_generator_macros.svh
// assertion macros for the noisy triangle sound generator
// expects aclk and aresetn in the scope of each use
`ifndef TRIANGLE_NOISE_SOUND_GENERATOR_MACROS_SVH
`define TRIANGLE_NOISE_SOUND_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TNSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TNSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tnsg_pkg.sv
// shared types, constants and helpers for the noisy triangle sound generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tnsg_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned TICK_W  = 24;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [TICK_W-1:0] TICK_MAX    = 24'hFF_FFFF;
    localparam logic [TICK_W-1:0] DECAY_TICKS = TICK_W'(4*2+2*8+4*3+5*2+4);
    localparam logic [VAL_W-1:0]  SLOPE_FLOOR = 16'h0007;
    localparam logic [7:0]        LOW_MASK    = 8'hFF;

    // zero ramp wait numerator and divider sizing
    localparam int unsigned ZERO_RAMP_NUM = 8*4*256;
    localparam int unsigned DIV_W         = $clog2(ZERO_RAMP_NUM + 1);
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        PH_FINISHED   = 3'd0,
        PH_PASS_START = 3'd1,
        PH_PICK       = 3'd2,
        PH_UP         = 3'd3,
        PH_DOWN       = 3'd4,
        PH_SNAP       = 3'd5,
        PH_PASS_END   = 3'd6,
        PH_ZERO       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DIV
    } seq_state_t;

    typedef enum logic [2:0] {
        REG_START_SLOPE    = 3'd0,
        REG_PASS_LENGTH    = 3'd1,
        REG_DECAY_ENABLE   = 3'd2,
        REG_SPUTTER_ENABLE = 3'd3,
        REG_INNER_WAIT     = 3'd4,
        REG_OUTER_WAIT     = 3'd5,
        REG_NOISE_SEED     = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]       start_slope;
        logic [VAL_W-1:0] pass_length;
        logic             decay_enable;
        logic             sputter_enable;
        logic [VAL_W-1:0] inner_wait;
        logic [VAL_W-1:0] outer_wait;
        logic [VAL_W-1:0] noise_seed;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TICK_W-1:0]  wait_ticks;
        logic               loops_forever;
        logic               finished;
    } result_t;

    // saturating tick accumulate
    function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
        logic [TICK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/triangle_noise_sound_generator.sv
// top level of the noisy triangle sound generator: register file, sequencer, output register
// depends on tnsg_pkg and tnsg_core
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_restart
//   m_        out        m_valid / m_ready   m_level, m_wait_ticks, m_loops_forever, m_finished
//   apb       in         psel/penable/pready paddr, pwdata, pwrite -> prdata
//
// A request walks the sound phases one per cycle, holding while a level waits to be taken
// or the zero-ramp restoring divider runs; a ramp or snap step gains a PICK phase when a
// new target is picked. Short decaying passes chain PASS_START, PICK, UP or DOWN, PASS_END.
// s_ready is high only while the sequencer is idle; one request is in flight at a time.
// A level waits in the output register; the sequencer holds until that register frees up.
// Synchronous active-low reset clears sequencer, sound state, m_valid, config (waits to 1).
`timescale 1ns / 1ps
`default_nettype none

module triangle_noise_sound_generator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tnsg_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [tnsg_pkg::DATA_W-1:0]        pwdata,
    output logic      [tnsg_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_restart,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [tnsg_pkg::LEVEL_W-1:0]       m_level,
    output logic      [tnsg_pkg::TICK_W-1:0]        m_wait_ticks,
    output logic                                    m_loops_forever,
    output logic                                    m_finished
);

    tnsg_pkg::cfg_t     cfg_reg;
    tnsg_pkg::reg_idx_t reg_idx;
    tnsg_pkg::result_t  res;
    tnsg_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic               emit;
    logic               slot_free;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = tnsg_pkg::reg_idx_t'(paddr[tnsg_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_slope    <= '0;
            cfg_reg.pass_length    <= '0;
            cfg_reg.decay_enable   <= 1'b0;
            cfg_reg.sputter_enable <= 1'b0;
            cfg_reg.inner_wait     <= 16'd1;
            cfg_reg.outer_wait     <= 16'd1;
            cfg_reg.noise_seed     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                tnsg_pkg::REG_START_SLOPE:    cfg_reg.start_slope    <= pwdata[7:0];
                tnsg_pkg::REG_PASS_LENGTH:    cfg_reg.pass_length    <= pwdata[15:0];
                tnsg_pkg::REG_DECAY_ENABLE:   cfg_reg.decay_enable   <= pwdata[0];
                tnsg_pkg::REG_SPUTTER_ENABLE: cfg_reg.sputter_enable <= pwdata[0];
                tnsg_pkg::REG_INNER_WAIT:     cfg_reg.inner_wait     <= pwdata[15:0];
                tnsg_pkg::REG_OUTER_WAIT:     cfg_reg.outer_wait     <= pwdata[15:0];
                tnsg_pkg::REG_NOISE_SEED:     cfg_reg.noise_seed     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            tnsg_pkg::REG_START_SLOPE:    prdata = {24'h0, cfg_reg.start_slope};
            tnsg_pkg::REG_PASS_LENGTH:    prdata = {16'h0, cfg_reg.pass_length};
            tnsg_pkg::REG_DECAY_ENABLE:   prdata = {31'h0, cfg_reg.decay_enable};
            tnsg_pkg::REG_SPUTTER_ENABLE: prdata = {31'h0, cfg_reg.sputter_enable};
            tnsg_pkg::REG_INNER_WAIT:     prdata = {16'h0, cfg_reg.inner_wait};
            tnsg_pkg::REG_OUTER_WAIT:     prdata = {16'h0, cfg_reg.outer_wait};
            tnsg_pkg::REG_NOISE_SEED:     prdata = {16'h0, cfg_reg.noise_seed};
            default:                      prdata = '0;
        endcase
    end

    // phase sequencer
    tnsg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .slot_free (slot_free),
        .emit      (emit),
        .res       (res)
    );

    assign slot_free = !out_valid_reg || m_ready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_level         = out_reg.level;
    assign m_wait_ticks    = out_reg.wait_ticks;
    assign m_loops_forever = out_reg.loops_forever;
    assign m_finished      = out_reg.finished;

endmodule

`default_nettype wire

FILE: design/tnsg_div.sv
// restoring divider: zero ramp numerator over a 16-bit slope, one quotient bit a cycle
// depends on tnsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tnsg_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [tnsg_pkg::VAL_W-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output logic [tnsg_pkg::DIV_W-1:0]         quotient
);

    logic [tnsg_pkg::VAL_W-1:0]     rem_reg, rem_next;
    logic [tnsg_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [tnsg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tnsg_pkg::VAL_W:0]       trial;
    logic                           fits;

    // one shift-subtract step
    always_comb begin
        trial     = {rem_reg, quo_reg[tnsg_pkg::DIV_W-1]};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = tnsg_pkg::DIV_W'(tnsg_pkg::ZERO_RAMP_NUM);
            cnt_next  = tnsg_pkg::DIV_CNT_W'(tnsg_pkg::DIV_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = fits ? tnsg_pkg::VAL_W'(trial - {1'b0, divisor})
                            : trial[tnsg_pkg::VAL_W-1:0];
            quo_next = {quo_reg[tnsg_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tnsg_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/tnsg_core.sv
// noisy triangle sequencer: one phase a cycle unless stalled, until a level is produced
// depends on tnsg_pkg, tnsg_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_noise_sound_generator_macros.svh"

module tnsg_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tnsg_pkg::cfg_t    cfg,
    input  wire logic              s_valid,
    input  wire logic              s_restart,
    output logic                   s_ready,
    input  wire logic              slot_free,
    output logic                   emit,
    output tnsg_pkg::result_t      res
);

    tnsg_pkg::seq_state_t           state_reg, state_next;
    tnsg_pkg::phase_t               phase_reg, phase_next;
    logic [tnsg_pkg::VAL_W-1:0]     noise_reg, noise_next;
    logic [tnsg_pkg::VAL_W-1:0]     cur_reg, cur_next;
    logic [tnsg_pkg::VAL_W-1:0]     target_reg, target_next;
    logic [tnsg_pkg::VAL_W-1:0]     step_reg, step_next;
    logic [tnsg_pkg::VAL_W-1:0]     base_reg, base_next;
    logic [tnsg_pkg::VAL_W-1:0]     steps_left_reg, steps_left_next;
    logic [tnsg_pkg::TICK_W-1:0]    pending_reg, pending_next;
    logic [tnsg_pkg::LEVEL_W-1:0]   last_level_reg, last_level_next;
    logic                           repeat_reg, repeat_next;

    logic                           div_start;
    logic                           div_busy;
    logic                           div_done;
    logic [tnsg_pkg::DIV_W-1:0]     div_quot;

    logic                           fb;
    logic [tnsg_pkg::VAL_W-1:0]     noise_shift;
    logic [tnsg_pkg::VAL_W-1:0]     pick_target;
    logic [tnsg_pkg::VAL_W-1:0]     steps_dec;
    logic [tnsg_pkg::VAL_W:0]       up_sum;
    logic [tnsg_pkg::VAL_W-1:0]     down_diff;
    logic [tnsg_pkg::VAL_W-1:0]     decayed;

    // divider for the zero ramp wait
    tnsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (base_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state and outputs
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        noise_next      = noise_reg;
        cur_next        = cur_reg;
        target_next     = target_reg;
        step_next       = step_reg;
        base_next       = base_reg;
        steps_left_next = steps_left_reg;
        pending_next    = pending_reg;
        last_level_next = last_level_reg;
        repeat_next     = repeat_reg;
        s_ready         = 1'b0;
        emit            = 1'b0;
        div_start       = 1'b0;
        res             = '0;

        fb          = cur_reg[11] ^ noise_reg[0];
        noise_shift = {fb, noise_reg[tnsg_pkg::VAL_W-1:1]};
        pick_target = {noise_shift[7:0], 8'h00};
        steps_dec   = steps_left_reg - 1'b1;
        up_sum      = {1'b0, cur_reg} + {1'b0, step_reg};
        down_diff   = cur_reg - step_reg;
        decayed     = base_reg - {3'b000, base_reg[tnsg_pkg::VAL_W-1:3]};

        case (state_reg)
            tnsg_pkg::SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // restart reloads the noise seed and slope from the registers and clears the sound state
                    if (s_restart) begin
                        noise_next      = cfg.noise_seed;
                        base_next       = {cfg.start_slope, 8'h00};
                        cur_next        = '0;
                        target_next     = '0;
                        step_next       = '0;
                        steps_left_next = '0;
                        pending_next    = '0;
                        last_level_next = '0;
                        repeat_next     = 1'b0;
                        phase_next      = tnsg_pkg::PH_PASS_START;
                    end
                    state_next = tnsg_pkg::SEQ_RUN;
                end
            end

            tnsg_pkg::SEQ_RUN: begin
                case (phase_reg)
                    tnsg_pkg::PH_PASS_START: begin
                        steps_left_next = cfg.pass_length;
                        cur_next        = {last_level_reg, 8'h00};
                        phase_next      = tnsg_pkg::PH_PICK;
                    end

                    // new random target; the slope is masked with noise when sputter is enabled
                    tnsg_pkg::PH_PICK: begin
                        noise_next  = noise_shift;
                        step_next   = cfg.sputter_enable
                                    ? (base_reg & {noise_shift[15:8], tnsg_pkg::LOW_MASK})
                                    : base_reg;
                        target_next = pick_target;
                        phase_next  = (cur_reg <= pick_target) ? tnsg_pkg::PH_UP
                                                               : tnsg_pkg::PH_DOWN;
                    end

                    // one ramp step, or pass end when the counter runs out
                    tnsg_pkg::PH_UP,
                    tnsg_pkg::PH_DOWN: begin
                        if (steps_dec == '0) begin
                            steps_left_next = '0;
                            phase_next      = tnsg_pkg::PH_PASS_END;
                        end else if (slot_free) begin
                            steps_left_next = steps_dec;
                            if (phase_reg == tnsg_pkg::PH_UP) begin
                                if (up_sum[tnsg_pkg::VAL_W]) begin
                                    phase_next = tnsg_pkg::PH_SNAP;
                                end else begin
                                    cur_next = up_sum[tnsg_pkg::VAL_W-1:0];
                                    if (up_sum[tnsg_pkg::VAL_W-1:0] > target_reg) begin
                                        phase_next = tnsg_pkg::PH_SNAP;
                                    end
                                end
                            end else begin
                                if (step_reg > cur_reg) begin
                                    phase_next = tnsg_pkg::PH_SNAP;
                                end else begin
                                    cur_next = down_diff;
                                    if (down_diff <= target_reg) begin
                                        phase_next = tnsg_pkg::PH_SNAP;
                                    end
                                end
                            end
                            emit                = 1'b1;
                            res.level           = cur_reg[15:8];
                            res.wait_ticks      = tnsg_pkg::sat_add(pending_reg,
                                                      {8'h00, cfg.inner_wait});
                            res.loops_forever   = repeat_reg;
                            res.finished        = 1'b0;
                        end
                    end

                    tnsg_pkg::PH_SNAP: begin
                        if (slot_free) begin
                            cur_next          = target_reg;
                            phase_next        = tnsg_pkg::PH_PICK;
                            emit              = 1'b1;
                            res.level         = target_reg[15:8];
                            res.wait_ticks    = tnsg_pkg::sat_add(pending_reg,
                                                    {8'h00, cfg.outer_wait});
                            res.loops_forever = repeat_reg;
                            res.finished      = 1'b0;
                        end
                    end

                    // decay the slope or mark the sound as repeating
                    tnsg_pkg::PH_PASS_END: begin
                        if (cfg.decay_enable) begin
                            base_next    = decayed;
                            pending_next = tnsg_pkg::sat_add(pending_reg,
                                                             tnsg_pkg::DECAY_TICKS);
                            phase_next   = (decayed > tnsg_pkg::SLOPE_FLOOR)
                                         ? tnsg_pkg::PH_PASS_START : tnsg_pkg::PH_ZERO;
                        end else begin
                            repeat_next = 1'b1;
                            phase_next  = tnsg_pkg::PH_ZERO;
                        end
                    end

                    // ramp to zero: finish at level zero, else divider wait unless slope is zero
                    tnsg_pkg::PH_ZERO: begin
                        if (last_level_reg == '0) begin
                            phase_next = tnsg_pkg::PH_FINISHED;
                        end else if (base_reg != '0) begin
                            div_start  = 1'b1;
                            state_next = tnsg_pkg::SEQ_DIV;
                        end else if (slot_free) begin
                            emit              = 1'b1;
                            res.level         = last_level_reg - 1'b1;
                            res.wait_ticks    = tnsg_pkg::TICK_MAX;
                            res.loops_forever = repeat_reg;
                            res.finished      = 1'b0;
                        end
                    end

                    default: begin
                        if (slot_free) begin
                            emit              = 1'b1;
                            res.level         = last_level_reg;
                            res.wait_ticks    = '0;
                            res.loops_forever = repeat_reg;
                            res.finished      = 1'b1;
                        end
                    end
                endcase
            end

            tnsg_pkg::SEQ_DIV: begin
                if (div_done && slot_free) begin
                    emit              = 1'b1;
                    res.level         = last_level_reg - 1'b1;
                    res.wait_ticks    = tnsg_pkg::sat_add(pending_reg,
                                            tnsg_pkg::TICK_W'(div_quot));
                    res.loops_forever = repeat_reg;
                    res.finished      = 1'b0;
                end
            end

            default: begin
                state_next = tnsg_pkg::SEQ_IDLE;
            end
        endcase

        // a produced level ends the request
        if (emit) begin
            last_level_next = res.level;
            pending_next    = '0;
            state_next      = tnsg_pkg::SEQ_IDLE;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tnsg_pkg::SEQ_IDLE;
            phase_reg      <= tnsg_pkg::PH_FINISHED;
            noise_reg      <= '0;
            cur_reg        <= '0;
            target_reg     <= '0;
            step_reg       <= '0;
            base_reg       <= '0;
            steps_left_reg <= '0;
            pending_reg    <= '0;
            last_level_reg <= '0;
            repeat_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            noise_reg      <= noise_next;
            cur_reg        <= cur_next;
            target_reg     <= target_next;
            step_reg       <= step_next;
            base_reg       <= base_next;
            steps_left_reg <= steps_left_next;
            pending_reg    <= pending_next;
            last_level_reg <= last_level_next;
            repeat_reg     <= repeat_next;
        end
    end

    // checks
    `TNSG_ASSERT_NOW(a_finished_silent, emit && res.finished, res.level == 8'h00, "finished level not zero")
    `TNSG_ASSERT_NEXT(a_emit_clears, emit, pending_reg == '0 && state_reg == tnsg_pkg::SEQ_IDLE, "ticks or state not cleared after a level")
    `TNSG_ASSERT_NOW(a_div_only_zero, state_reg == tnsg_pkg::SEQ_DIV, phase_reg == tnsg_pkg::PH_ZERO && base_reg != '0, "divide outside zero ramp")
    `TNSG_ASSERT_NEXT(a_div_starts, div_start, div_busy && !div_done, "divider did not start")

endmodule

`default_nettype wire
